>>> rtl/flf_pkg.sv
// ----------------------------------------------------------------------------
// flf_pkg
// Shared types, constants and helpers for the first-order lag filter.
// ----------------------------------------------------------------------------
package flf_pkg;

    localparam int          CHANNELS_DEF = 16;
    localparam logic [31:0] DT_RESET     = 32'd655;
    localparam logic [31:0] ONE_Q31      = 32'h8000_0000;
    localparam logic [3:0]  SERIES_LAST  = 4'd13;
    localparam logic [2:0]  SQUARE_LAST  = 3'd4;
    localparam int          HIST_W       = 65;  // {primed, last_output, last_input}

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_HIST,
        OP_DIV_R,
        OP_SER_MUL,
        OP_SER_RCP,
        OP_SER_FIX,
        OP_SER_END,
        OP_GAIN_A,
        OP_SQ_MUL,
        OP_SQ_TAKE,
        OP_DIV_G,
        OP_ROUND,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_WRITE
    } dp_op_t;

    typedef struct packed {
        logic div_done;
        logic q_big;
        logic bypass;
        logic k_last;
        logic gain_mode;
        logic sq_last;
        logic clr_last;
    } dp_stat_t;

    // floor((2^32 - 1) / d); q0 = (t * recip) >> 32 is then floor(t/d) or one less
    function automatic logic [31:0] flf_recip(input logic [3:0] d);
        logic [31:0] r;
        case (d)
            4'd1:    r = 32'd4294967295;
            4'd2:    r = 32'd2147483647;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741823;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870911;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            4'd13:   r = 32'd330382099;
            4'd14:   r = 32'd306783378;
            default: r = 32'd4294967295;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] flf_clamp_unit(input logic signed [33:0] s);
        logic [31:0] r;
        if (s < 0) begin
            r = 32'd0;
        end else if (s > $signed({2'b00, ONE_Q31})) begin
            r = ONE_Q31;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] flf_sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/first_order_lag_filter_core.sv
// ----------------------------------------------------------------------------
// first_order_lag_filter_core
// Multichannel first-order lag filter, exact discretization, Q15.16 samples.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass over all CHANNELS entries
// runs through the history RAM before the first item is taken. A pass-through
// item (channel out of range, zero step time or zero time constant) goes
// straight from the history read to the result. Otherwise the 64-bit restoring
// divider forms dt/tau, and then: dt/tau below one, a 13-term series, each term
// a multiply, a reciprocal and a fix step on the shared multiplier; dt/tau from
// one to 32, the same series, five squarings and a second division; dt/tau of 32
// or more, the second division alone. A new item is taken while the last result waits.
module first_order_lag_filter_core #(
    parameter int CHANNELS = flf_pkg::CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_channel,
    input  logic signed [31:0] s_sample,
    input  logic [31:0]        s_time_constant,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_out_channel,
    output logic signed [31:0] m_filtered,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import flf_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    dp_op_t              op;
    dp_stat_t            stat;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [HIST_W-1:0]   ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;

    flf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .op      (op)
    );

    flf_dp #(.CHANNELS(CHANNELS)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op              (op),
        .stat            (stat),
        .cfg_we          (cfg_valid),
        .cfg_data        (cfg_data),
        .s_channel       (s_channel),
        .s_sample        (s_sample),
        .s_time_constant (s_time_constant),
        .s_restart       (s_restart),
        .m_out_channel   (m_out_channel),
        .m_filtered      (m_filtered),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata)
    );

    flf_ram #(.WIDTH(HIST_W), .DEPTH(CHANNELS)) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

>>> rtl/flf_ram.sv
// ----------------------------------------------------------------------------
// flf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module flf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/flf_div.sv
// ----------------------------------------------------------------------------
// flf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module flf_div #(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    shifted;

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        if (start) begin
            cnt_next = CW'(W);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = shifted - {1'b0, dvs_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (cnt_reg == '0))
        else $error("divider started while busy");
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(cnt_reg) == CW'(1)))
        else $error("divider done without last step");
    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cnt_reg != '0) && !start) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("divider count skipped");
endmodule

>>> rtl/flf_ctrl.sv
// ----------------------------------------------------------------------------
// flf_ctrl
// Sequencer: clearing pass, item intake, series/exp/divide steps, result.
// ----------------------------------------------------------------------------
module flf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  flf_pkg::dp_stat_t stat,
    output flf_pkg::dp_op_t   op
);
    import flf_pkg::*;

    typedef enum logic [16:0] {
        ST_CLEAR  = 17'd1 << 0,
        ST_IDLE   = 17'd1 << 1,
        ST_HIST   = 17'd1 << 2,
        ST_DIVR   = 17'd1 << 3,
        ST_SMUL   = 17'd1 << 4,
        ST_SRCP   = 17'd1 << 5,
        ST_SFIX   = 17'd1 << 6,
        ST_SEND   = 17'd1 << 7,
        ST_GAINA  = 17'd1 << 8,
        ST_SQMUL  = 17'd1 << 9,
        ST_SQTAKE = 17'd1 << 10,
        ST_DIVG   = 17'd1 << 11,
        ST_ROUND  = 17'd1 << 12,
        ST_M1     = 17'd1 << 13,
        ST_M2     = 17'd1 << 14,
        ST_M3     = 17'd1 << 15,
        ST_WRITE  = 17'd1 << 16
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        op           = OP_NONE;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_CLEAR: begin
                op = OP_CLEAR;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = ST_HIST;
                end
            end
            ST_HIST: begin
                op         = OP_HIST;
                state_next = stat.bypass ? ST_WRITE : ST_DIVR;
            end
            ST_DIVR: begin
                op = OP_DIV_R;
                if (stat.div_done) state_next = stat.q_big ? ST_DIVG : ST_SMUL;
            end
            ST_SMUL: begin
                op         = OP_SER_MUL;
                state_next = ST_SRCP;
            end
            ST_SRCP: begin
                op         = OP_SER_RCP;
                state_next = ST_SFIX;
            end
            ST_SFIX: begin
                op         = OP_SER_FIX;
                state_next = stat.k_last ? ST_SEND : ST_SMUL;
            end
            ST_SEND: begin
                op         = OP_SER_END;
                state_next = stat.gain_mode ? ST_GAINA : ST_SQMUL;
            end
            ST_GAINA: begin
                op         = OP_GAIN_A;
                state_next = ST_ROUND;
            end
            ST_SQMUL: begin
                op         = OP_SQ_MUL;
                state_next = ST_SQTAKE;
            end
            ST_SQTAKE: begin
                op         = OP_SQ_TAKE;
                state_next = stat.sq_last ? ST_DIVG : ST_SQMUL;
            end
            ST_DIVG: begin
                op = OP_DIV_G;
                if (stat.div_done) state_next = ST_ROUND;
            end
            ST_ROUND: begin
                op         = OP_ROUND;
                state_next = ST_M1;
            end
            ST_M1: begin
                op         = OP_M1;
                state_next = ST_M2;
            end
            ST_M2: begin
                op         = OP_M2;
                state_next = ST_M3;
            end
            ST_M3: begin
                op         = OP_M3;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    op           = OP_WRITE;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_write_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && !out_free) |=> (state_reg == ST_WRITE))
        else $error("result dropped while output busy");
    a_write_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == ST_DIVR || state_reg == ST_DIVG))
        else $error("divider finished outside a wait state");
endmodule

>>> rtl/flf_dp.sv
// ----------------------------------------------------------------------------
// flf_dp
// Datapath: operand registers, series unit, squaring, divider, output mix.
// ----------------------------------------------------------------------------
module flf_dp #(
    parameter int CHANNELS = flf_pkg::CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  flf_pkg::dp_op_t       op,
    output flf_pkg::dp_stat_t     stat,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_data,
    input  logic [3:0]            s_channel,
    input  logic signed [31:0]    s_sample,
    input  logic [31:0]           s_time_constant,
    input  logic                  s_restart,
    output logic [3:0]            m_out_channel,
    output logic signed [31:0]    m_filtered,
    output logic                  ram_we,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ram_waddr,
    output logic [flf_pkg::HIST_W-1:0] ram_wdata,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ram_raddr,
    input  logic [flf_pkg::HIST_W-1:0] ram_rdata
);
    import flf_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [31:0]        dt_reg;
    logic [3:0]         ch_reg;
    logic signed [31:0] x_reg, in0_reg, out0_reg, y_reg;
    logic [31:0]        tau_reg;
    logic               rst_reg;
    logic [63:0]        r_reg, prod_reg;
    logic [31:0]        t_reg, tq_reg, q0_reg, a_reg, g_reg;
    logic signed [33:0] s_reg;
    logic [3:0]         k_reg;
    logic [2:0]         sq_reg;
    logic signed [34:0] term1_reg;
    logic               neg_reg;
    logic [AW-1:0]      clr_reg;
    logic [3:0]         och_reg;
    logic signed [31:0] oy_reg;

    logic        div_start, div_done;
    logic [63:0] div_dvd, div_dvs, div_quo;

    logic               ch_ok, bypass, gain_mode, fresh;
    logic [31:0]        rx, recip, s_clamp, ma, mb, t_fix, one_minus_sq;
    logic [3:0]         dsel;
    logic [63:0]        mul32, mulr, rsum;
    logic [35:0]        qd, rem;
    logic signed [32:0] d1, d2, dsel_s;
    logic [32:0]        mag;
    logic [31:0]        csel;
    logic [64:0]        mulm;
    logic [33:0]        rq;
    logic signed [34:0] rterm;
    logic signed [35:0] ysum;
    logic [32:0]        a_inc, g_inc;

    flf_div #(.W(64)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign ch_ok     = ({28'd0, ch_reg} < 32'(CHANNELS));
    assign bypass    = !ch_ok || (dt_reg == '0) || (tau_reg == '0);
    assign gain_mode = (r_reg[63:32] == '0);
    assign rx        = gain_mode ? r_reg[31:0] : r_reg[36:5];
    assign dsel      = gain_mode ? (k_reg + 4'd1) : k_reg;
    assign recip     = flf_recip(dsel);
    assign s_clamp   = flf_clamp_unit(s_reg);
    assign fresh     = !ram_rdata[HIST_W-1] || rst_reg;

    // shared 32x32 multiplier for series terms, gain product and squaring
    always_comb begin
        case (op)
            OP_SER_MUL: begin ma = t_reg;       mb = rx;      end
            OP_SER_END: begin ma = r_reg[31:0]; mb = s_clamp; end
            OP_SQ_MUL:  begin ma = a_reg;       mb = a_reg;   end
            default:    begin ma = t_reg;       mb = rx;      end
        endcase
    end
    assign mul32 = {32'd0, ma} * {32'd0, mb};
    assign mulr  = {32'd0, prod_reg[63:32]} * {32'd0, recip};

    // one correction step after the reciprocal estimate
    assign qd    = {4'd0, q0_reg} * {32'd0, dsel};
    assign rem   = {4'd0, tq_reg} - qd;
    assign t_fix = q0_reg + ((rem >= {32'd0, dsel}) ? 32'd1 : 32'd0);

    assign one_minus_sq = ONE_Q31 - prod_reg[62:31];

    assign d1     = {out0_reg[31], out0_reg} - {in0_reg[31], in0_reg};
    assign d2     = {in0_reg[31], in0_reg} - {x_reg[31], x_reg};
    assign dsel_s = (op == OP_M1) ? d1 : d2;
    assign mag    = dsel_s[32] ? 33'(-dsel_s) : 33'(dsel_s);
    assign csel   = (op == OP_M1) ? a_reg : g_reg;
    assign mulm   = {32'd0, mag} * {33'd0, csel};

    // round half away from zero on the magnitude, then restore sign
    assign rsum  = prod_reg + 64'd536870912;
    assign rq    = rsum[63:30];
    assign rterm = neg_reg ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    assign ysum  = {{4{x_reg[31]}}, x_reg} + {term1_reg[34], term1_reg}
                 + {rterm[34], rterm};

    assign a_inc = {1'b0, a_reg} + 33'd1;
    assign g_inc = {1'b0, g_reg} + 33'd1;

    always_comb begin
        div_start = 1'b0;
        div_dvd   = {dt_reg, 32'd0};
        div_dvs   = {32'd0, tau_reg};
        case (op)
            OP_HIST: begin
                div_start = !bypass;
            end
            OP_DIV_R: begin
                div_start = div_done && (div_quo[63:37] != '0);
                div_dvd   = {ONE_Q31, 32'd0};
                div_dvs   = div_quo;
            end
            OP_SQ_TAKE: begin
                div_start = (sq_reg == SQUARE_LAST);
                div_dvd   = {one_minus_sq, 32'd0};
                div_dvs   = r_reg;
            end
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg  <= DT_RESET;
            clr_reg <= '0;
        end else begin
            if (cfg_we) dt_reg <= cfg_data;
            if (op == OP_CLEAR) clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD: begin
                ch_reg  <= s_channel;
                x_reg   <= s_sample;
                tau_reg <= s_time_constant;
                rst_reg <= s_restart;
            end
            OP_HIST: begin
                in0_reg  <= fresh ? x_reg : $signed(ram_rdata[31:0]);
                out0_reg <= fresh ? x_reg : $signed(ram_rdata[63:32]);
                y_reg    <= x_reg;
            end
            OP_DIV_R: begin
                if (div_done) begin
                    r_reg <= div_quo;
                    t_reg <= ONE_Q31;
                    s_reg <= $signed({2'b00, ONE_Q31});
                    k_reg <= 4'd1;
                    a_reg <= '0;
                end
            end
            OP_SER_MUL: prod_reg <= mul32;
            OP_SER_RCP: begin
                tq_reg <= prod_reg[63:32];
                q0_reg <= mulr[63:32];
            end
            OP_SER_FIX: begin
                t_reg <= t_fix;
                s_reg <= k_reg[0] ? (s_reg - $signed({2'b00, t_fix}))
                                  : (s_reg + $signed({2'b00, t_fix}));
                k_reg <= k_reg + 4'd1;
            end
            OP_SER_END: begin
                if (gain_mode) begin
                    g_reg    <= s_clamp;
                    prod_reg <= mul32;
                end else begin
                    a_reg  <= s_clamp;
                    sq_reg <= '0;
                end
            end
            OP_GAIN_A:  a_reg <= ONE_Q31 - prod_reg[63:32];
            OP_SQ_MUL:  prod_reg <= mul32;
            OP_SQ_TAKE: begin
                a_reg  <= prod_reg[62:31];
                sq_reg <= sq_reg + 3'd1;
            end
            OP_DIV_G: begin
                if (div_done) g_reg <= (div_quo > {32'd0, ONE_Q31}) ? ONE_Q31
                                                                    : div_quo[31:0];
            end
            OP_ROUND: begin
                a_reg <= a_inc[32:1];
                g_reg <= g_inc[32:1];
            end
            OP_M1: begin
                prod_reg <= mulm[63:0];
                neg_reg  <= dsel_s[32];
            end
            OP_M2: begin
                term1_reg <= rterm;
                prod_reg  <= mulm[63:0];
                neg_reg   <= dsel_s[32];
            end
            OP_M3: y_reg <= flf_sat32(ysum);
            OP_WRITE: begin
                och_reg <= ch_reg;
                oy_reg  <= y_reg;
            end
            default: ;
        endcase
    end

    assign ram_we    = (op == OP_CLEAR) || ((op == OP_WRITE) && ch_ok);
    assign ram_waddr = (op == OP_CLEAR) ? clr_reg : AW'(ch_reg);
    assign ram_wdata = (op == OP_CLEAR) ? '0 : {1'b1, y_reg, x_reg};
    assign ram_raddr = AW'(s_channel);

    assign m_out_channel = och_reg;
    assign m_filtered    = oy_reg;

    assign stat.div_done  = div_done;
    assign stat.q_big     = (div_quo[63:37] != '0);
    assign stat.bypass    = bypass;
    assign stat.k_last    = (k_reg == SERIES_LAST);
    assign stat.gain_mode = gain_mode;
    assign stat.sq_last   = (sq_reg == SQUARE_LAST);
    assign stat.clr_last  = (clr_reg == AW'(CHANNELS - 1));
endmodule

>>> tb/tb_first_order_lag_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_order_lag_filter_core
// Drives samples over several step-time settings and compares every filtered
// value with a bit-exact fixed-point predictor of the lag filter.
// ----------------------------------------------------------------------------
module tb_first_order_lag_filter_core;

    typedef struct {
        logic [3:0]         channel;
        logic signed [31:0] sample;
        logic [31:0]        tau;
        logic               restart;
    } sample_item_t;

    typedef struct {
        logic [3:0]         channel;
        logic signed [31:0] filtered;
    } filter_out_t;

    localparam logic [63:0] UNIT_Q31 = 64'h8000_0000;
    localparam logic [63:0] ONE_Q32  = 64'h1_0000_0000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_channel = '0;
    logic signed [31:0] s_sample = '0;
    logic [31:0]        s_time_constant = '0;
    logic               s_restart = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [3:0]         m_out_channel;
    logic signed [31:0] m_filtered;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [31:0]        cfg_data = '0;

    first_order_lag_filter_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_channel(s_channel),
        .s_sample(s_sample), .s_time_constant(s_time_constant), .s_restart(s_restart),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_channel(m_out_channel),
        .m_filtered(m_filtered),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    sample_item_t       pending_samples[$];
    filter_out_t        expected_outputs[$];
    logic [31:0]        dt_shadow = flf_pkg::DT_RESET;
    logic signed [31:0] hist_in[16];
    logic signed [31:0] hist_out[16];
    logic               hist_primed[16];
    logic               item_taken = 1'b0;
    logic               hold_off = 1'b0;
    int                 burst_left = 0;
    int                 gap_left = 0;
    int                 stall_mode = 0;
    int                 stall_left = 0;
    int                 errors = 0;
    int                 items_in = 0;
    int                 results_out = 0;
    int                 dt_settings = 0;

    // truncating power series; gain form divides term k by k+1, exp form by k
    function automatic logic [63:0] series_q31(input logic [63:0] v, input bit gain_form);
        logic [63:0]        t;
        logic signed [63:0] s;
        t = UNIT_Q31;
        s = $signed(t);
        for (int k = 1; k <= 13; k++) begin
            t = ((t * v) >> 32) / (gain_form ? k + 1 : k);
            if (k % 2 == 1) s = s - $signed(t);
            else s = s + $signed(t);
        end
        if (s < 0) return 64'd0;
        if (s > $signed(UNIT_Q31)) return UNIT_Q31;
        return s;
    endfunction

    // d * c / 2^30, ties away from zero
    function automatic logic signed [63:0] scale_q30(input logic signed [63:0] d,
                                                     input logic [63:0] c);
        logic [63:0] m;
        logic [63:0] q;
        m = (d < 0) ? -d : d;
        q = (m * c + 64'h2000_0000) >> 30;
        return (d < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] lag_output(
        input logic signed [31:0] x, input logic [31:0] tau, input logic [31:0] dt,
        input logic signed [31:0] in0, input logic signed [31:0] out0);
        logic [63:0]        r;
        logic [63:0]        a;
        logic [63:0]        g;
        logic signed [63:0] y;
        if (dt == 0 || tau == 0) return x;
        r = {dt, 32'd0} / {32'd0, tau};
        if (r < ONE_Q32) begin
            g = series_q31(r, 1'b1);
            a = UNIT_Q31 - ((r * g) >> 32);
        end else begin
            if (r >= (ONE_Q32 << 5)) begin
                a = 0;
            end else begin
                a = series_q31(r >> 5, 1'b0);
                for (int n = 0; n < 5; n++) a = (a * a) >> 31;
            end
            g = ((UNIT_Q31 - a) << 32) / r;
            if (g > UNIT_Q31) g = UNIT_Q31;
        end
        a = (a + 1) >> 1;
        g = (g + 1) >> 1;
        y = 64'(x) + scale_q30(64'(out0) - 64'(in0), a) + scale_q30(64'(in0) - 64'(x), g);
        if (y > 64'sd2147483647) y = 64'sd2147483647;
        if (y < -64'sd2147483648) y = -64'sd2147483648;
        return y[31:0];
    endfunction

    // input side: record acceptance and predict
    always @(posedge aclk) begin
        filter_out_t        e;
        logic [3:0]         c;
        logic signed [31:0] y;
        item_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            c = s_channel;
            if (!hist_primed[c] || s_restart) begin
                hist_in[c]  = s_sample;
                hist_out[c] = s_sample;
                hist_primed[c] = 1'b1;
            end
            y = lag_output(s_sample, s_time_constant, dt_shadow, hist_in[c], hist_out[c]);
            hist_in[c]  = s_sample;
            hist_out[c] = y;
            e.channel  = c;
            e.filtered = y;
            expected_outputs.push_back(e);
            items_in++;
        end
    end

    // result side
    always @(posedge aclk) begin
        filter_out_t e;
        if (aresetn && m_valid && m_ready) begin
            results_out++;
            if (expected_outputs.size() == 0) begin
                $error("unexpected item: channel %0d filtered %0d", m_out_channel, m_filtered);
                errors++;
            end else begin
                e = expected_outputs.pop_front();
                if (m_out_channel !== e.channel) begin
                    $error("out_channel: expected %0d actual %0d", e.channel, m_out_channel);
                    errors++;
                end
                if (m_filtered !== e.filtered) begin
                    $error("filtered: expected %0d actual %0d", e.filtered, m_filtered);
                    errors++;
                end
            end
        end
    end

    // sender in bursts with gaps
    always @(negedge aclk) begin
        sample_item_t it;
        if (aresetn && (!s_valid || item_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (hold_off || pending_samples.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                it = pending_samples.pop_front();
                s_valid         <= 1'b1;
                s_channel       <= it.channel;
                s_sample        <= it.sample;
                s_time_constant <= it.tau;
                s_restart       <= it.restart;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stalls: mode changes every stretch
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 600);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= $urandom_range(0, 1);
            end
            2: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_ready <= ($urandom_range(0, 40) != 0) ? m_ready : ~m_ready;
            end
        endcase
    end

    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_valid || expected_outputs.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_step_time(input logic [31:0] dt);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= dt;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        dt_shadow = dt;
        dt_settings++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(input logic [3:0] ch, input logic signed [31:0] x,
                                input logic [31:0] tau, input logic rs);
        sample_item_t it;
        it.channel = ch;
        it.sample  = x;
        it.tau     = tau;
        it.restart = rs;
        pending_samples.push_back(it);
    endtask

    // tau spread so dt/tau lands below one, between one and 32, and beyond
    function automatic logic [31:0] random_tau(input logic [31:0] dt);
        logic [31:0] d;
        d = (dt == 0) ? 32'd655 : dt;
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: return $urandom_range(1, 4096);
            3: return (d < 32'h0100_0000) ? d * $urandom_range(2, 200) : $urandom;
            4: return d / $urandom_range(1, 31) + $urandom_range(0, 3);
            5: return d / $urandom_range(32, 5000) + 1;
            default: return d;
        endcase
    endfunction

    task automatic queue_random(input int n, input logic [31:0] dt);
        logic signed [31:0] x;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: x = $urandom;
                1: x = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
                2: x = ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF - $urandom_range(0, 99)
                                              : 32'sh8000_0000 + $urandom_range(0, 99);
                default: x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            endcase
            queue_sample($urandom_range(0, 15), x, random_tau(dt),
                         ($urandom_range(0, 9) == 0));
        end
    endtask

    initial begin
        logic [31:0] dt_list[6];
        for (int i = 0; i < 16; i++) hist_primed[i] = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset step time, each coefficient regime, extremes
        queue_sample(4'd0, 32'sh0001_0000, 32'h0001_0000, 1'b0);
        queue_sample(4'd0, 32'sh0002_0000, 32'h0001_0000, 1'b0);
        queue_sample(4'd0, 32'sh0002_0000, 32'd2620, 1'b0);
        queue_sample(4'd0, -32'sh0003_0000, 32'd100, 1'b0);
        queue_sample(4'd0, 32'sh7FFF_FFFF, 32'd1, 1'b0);
        queue_sample(4'd0, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_sample(4'd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_sample(4'd0, 32'sh0000_1234, 32'd0, 1'b0);
        queue_sample(4'd0, 32'sh0005_0000, 32'h0001_0000, 1'b1);
        queue_sample(4'd15, 32'sh8000_0000, 32'd20, 1'b0);
        queue_sample(4'd15, 32'sh7FFF_FFFF, 32'd20, 1'b0);
        queue_sample(4'd15, 32'sh8000_0000, 32'd21, 1'b0);
        queue_sample(4'd7, 32'sh7FFF_FFFF, 32'd655, 1'b0);
        queue_sample(4'd7, 32'sh8000_0000, 32'd654, 1'b0);
        queue_sample(4'd7, 32'sh0000_0000, 32'd656, 1'b1);
        queue_sample(4'd8, 32'shFFFF_FFFF, 32'd5, 1'b1);
        queue_sample(4'd8, 32'sh0000_0001, 32'd5, 1'b0);

        dt_list = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000, 32'd655, $urandom};
        write_step_time(32'd0);
        queue_sample(4'd3, 32'sh1234_5678, 32'd7, 1'b0);
        queue_sample(4'd3, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b1);
        foreach (dt_list[p]) begin
            write_step_time(dt_list[p]);
            queue_random(60, dt_list[p]);
            // wait until every result is back, then hold the sender off before the next batch
            while (pending_samples.size() != 0 || s_valid || expected_outputs.size() != 0)
                @(posedge aclk);
            hold_off <= 1'b1;
            repeat (20) @(posedge aclk);
            hold_off <= 1'b0;
            queue_random(60, dt_list[p]);
        end
        wait_idle();

        $display("covered %0d items, %0d results over %0d step-time settings",
                 items_in, results_out, dt_settings);
        if (errors == 0 && expected_outputs.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (expected_outputs.size() != 0) $error("%0d items never came back",
                                                     expected_outputs.size());
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
